// ===== rtl/ypcb_pkg.sv =====
// shared types, constants and the arctangent table for the camera basis block
package ypcb_pkg;

   localparam int unsigned CORDIC_STEPS = 16;

   localparam logic [24:0] FULL_TURN    = 25'd23592960;
   localparam logic [24:0] HALF_TURN    = 25'd11796480;
   localparam logic [24:0] QUARTER_TURN = 25'd5898240;
   localparam logic [24:0] PITCH_LIMIT  = 25'd5832704;
   localparam logic [14:0] UNIT         = 15'd16384;
   localparam logic [32:0] CORDIC_START = 33'd652032874;

   // 128 turns lifts any signed sum above zero before the reduction
   localparam logic [33:0] WRAP_BIAS    = 34'd3019898880;

   localparam logic [2:0] CSR_MOUSE_GAIN  = 3'd0;
   localparam logic [2:0] CSR_WORLD_UP_X  = 3'd1;
   localparam logic [2:0] CSR_WORLD_UP_Y  = 3'd2;
   localparam logic [2:0] CSR_WORLD_UP_Z  = 3'd3;
   localparam logic [2:0] CSR_START_YAW   = 3'd4;
   localparam logic [2:0] CSR_START_PITCH = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ANG_X,
      ST_ANG_Y,
      ST_PIT,
      ST_RED_YAW,
      ST_RED_PIT,
      ST_CY_GO,
      ST_CY_WAIT,
      ST_CP_GO,
      ST_CP_WAIT,
      ST_FR0,
      ST_FR1,
      ST_FR2,
      ST_NSQ,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_DV_GO,
      ST_DV_WAIT,
      ST_CROSS,
      ST_DONE
   } state_type;

   // arctangent of 2^-i in degrees times 65536
   function automatic logic [21:0] atan_deg(input logic [3:0] step);
      logic [21:0] r;
      case (step)
         4'd0:    r = 22'd2949120;
         4'd1:    r = 22'd1740967;
         4'd2:    r = 22'd919879;
         4'd3:    r = 22'd466945;
         4'd4:    r = 22'd234379;
         4'd5:    r = 22'd117266;
         4'd6:    r = 22'd58666;
         4'd7:    r = 22'd29335;
         4'd8:    r = 22'd14668;
         4'd9:    r = 22'd7334;
         4'd10:   r = 22'd3667;
         4'd11:   r = 22'd1833;
         4'd12:   r = 22'd917;
         4'd13:   r = 22'd458;
         4'd14:   r = 22'd229;
         4'd15:   r = 22'd115;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ypcb_cordic.sv =====
// iterative cordic rotator giving cos and sin of an angle in degrees
module ypcb_cordic import ypcb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [25:0] angle,
   output logic               done,
   output logic signed [32:0] cos_val,
   output logic signed [32:0] sin_val
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [3:0]         step_ff, step_in;
   logic               flip_ff, flip_in;
   logic signed [32:0] x_ff, x_in, y_ff, y_in;
   logic signed [25:0] z_ff, z_in;
   logic signed [25:0] z_fold;
   logic               fold_flip;
   logic signed [32:0] dx, dy;
   logic signed [25:0] at;

   always_comb begin
      z_fold    = angle;
      fold_flip = 1'b0;
      if (z_fold > $signed({1'b0, HALF_TURN})) begin
         z_fold = z_fold - $signed({1'b0, FULL_TURN});
      end
      if (z_fold > $signed({1'b0, QUARTER_TURN})) begin
         z_fold    = z_fold - $signed({1'b0, HALF_TURN});
         fold_flip = 1'b1;
      end else if (z_fold < -$signed({1'b0, QUARTER_TURN})) begin
         z_fold    = z_fold + $signed({1'b0, HALF_TURN});
         fold_flip = 1'b1;
      end
   end

   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign at = $signed({4'b0, atan_deg(step_ff)});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         flip_in = fold_flip;
         x_in    = $signed(CORDIC_START);
         y_in    = '0;
         z_in    = z_fold;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done    = done_ff;
   assign cos_val = flip_ff ? -x_ff : x_ff;
   assign sin_val = flip_ff ? -y_ff : y_ff;

endmodule

// ===== rtl/ypcb_isqrt.sv =====
// bit-serial integer square root, one result bit a cycle
module ypcb_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [63:0] n_ff, n_in, res_ff, res_in, rbit_ff, rbit_in;
   logic [63:0] trial;

   assign trial = res_ff + rbit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      rbit_in = rbit_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         n_in    = radicand;
         res_in  = '0;
         rbit_in = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + rbit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         rbit_in = rbit_ff >> 2;
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      res_ff  <= res_in;
      rbit_ff <= rbit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ===== rtl/ypcb_div.sv =====
// restoring divider for the unit scaling, quotient limited to 1.0
module ypcb_div import ypcb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [46:0] numer,
   input  logic [31:0] denom,
   output logic        done,
   output logic [14:0] quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  step_ff, step_in;
   logic [47:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [15:0] q_ff, q_in;
   logic [47:0] den_sh;

   assign den_sh = {16'b0, den_ff} << step_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         den_in  = denom;
         rem_in  = {1'b0, numer};
         q_in    = '0;
         step_in = 4'd15;
         // a quotient of 2^16 or more saturates at once
         if ({1'b0, numer} >= {denom, 16'b0}) begin
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_ff >= den_sh) begin
            rem_in        = rem_ff - den_sh;
            q_in[step_ff] = 1'b1;
         end
         step_in = step_ff - 4'd1;
         if (step_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = (q_ff > {1'b0, UNIT}) ? UNIT : q_ff[14:0];

endmodule

// ===== rtl/yaw_pitch_camera_basis_top.sv =====
// camera angle update and front, right and up basis vectors from mouse deltas
//
//  channel   dir   handshake            payload
//  req_      in    req_tvalid/tready    tdata: delta_x, delta_y; tuser: clamp_pitch
//  rsp_      out   rsp_tvalid/tready    tdata: front, right, up, yaw_now, pitch_now
//  csr_      in    csr_we               csr_index, csr_wdata
//
//  each item runs two 16-step cordic runs, then three normalisations,
//  each a 32-step square root and three divides of up to 16 steps.
//  one shared multiplier serves the angle, front, square and cross product terms.
//  reset is synchronous; no clearing pass is needed.
//  req_tready is high only in idle; a finished result waits in the output
//  register while the next item is taken, and the sequencer holds at its end
//  until that register is free.
module yaw_pitch_camera_basis_top import ypcb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // delta_x, delta_y
   input  logic         req_tuser,   // clamp_pitch
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // front_x/y/z, right_x/y/z, up_x/y/z, yaw_now, pitch_now, zero fill
   output logic [199:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [24:0]  csr_wdata
);

   state_type          state_ff, state_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [1:0]         phase_ff, phase_in;
   logic signed [15:0] dx_ff, dx_in, dy_ff, dy_in;
   logic               clamp_ff, clamp_in;
   logic [15:0]        gain_ff, gain_in;
   logic signed [15:0] wu_ff [3];
   logic signed [15:0] wu_in [3];
   logic [24:0]        yaw_ff, yaw_in;
   logic signed [24:0] pitch_ff, pitch_in;
   logic [33:0]        red_ff, red_in;
   logic signed [33:0] preg_ff, preg_in;
   logic signed [32:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;
   logic signed [32:0] vec_ff [3];
   logic signed [32:0] vec_in [3];
   logic [63:0]        sum_ff, sum_in;
   logic [31:0]        len_ff, len_in;
   logic signed [15:0] fr_ff [3];
   logic signed [15:0] fr_in [3];
   logic signed [15:0] rt_ff [3];
   logic signed [15:0] rt_in [3];
   logic signed [15:0] up_ff [3];
   logic signed [15:0] up_in [3];
   logic signed [65:0] product_ff;
   logic signed [32:0] mul_a, mul_b;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [199:0]       rsp_data_ff, rsp_data_in;

   logic               cor_start, cor_done;
   logic signed [25:0] cor_angle;
   logic signed [32:0] cor_cos, cor_sin;
   logic               sq_start, sq_done;
   logic [31:0]        sq_root;
   logic               dv_start, dv_done;
   logic [46:0]        dv_numer;
   logic [14:0]        dv_quot;

   logic [33:0]        full_sh;
   logic               red_ge;
   logic [33:0]        red_next;
   logic signed [34:0] yaw_sum;
   logic signed [33:0] pit_sum;
   logic signed [32:0] rnd_prod;
   logic [65:0]        prod_mag;
   logic [32:0]        prod_rnd;
   logic signed [32:0] cur_vec;
   logic [31:0]        cur_mag;
   logic signed [15:0] nrm_val;
   logic signed [15:0] cr_a [3];
   logic signed [15:0] cr_b [3];
   logic signed [15:0] term_a, term_b;
   logic [24:0]        load_yaw;

   // wrap reduction: one compare and subtract of a shifted turn per cycle
   assign full_sh  = 34'(FULL_TURN) << cnt_ff;
   assign red_ge   = red_ff >= full_sh;
   assign red_next = red_ge ? red_ff - full_sh : red_ff;
   assign yaw_sum  = $signed({10'b0, yaw_ff}) + 35'($signed(product_ff[32:0]));
   assign pit_sum  = 34'(pitch_ff) + 34'($signed(product_ff[32:0]));

   // round half away from zero of a q30 product
   assign prod_mag = product_ff[65] ? 66'(-product_ff) : 66'(product_ff);
   assign prod_rnd = 33'((prod_mag + 66'(1 << 29)) >> 30);
   assign rnd_prod = product_ff[65] ? -$signed(prod_rnd) : $signed(prod_rnd);

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    cur_vec = vec_ff[0];
         2'd1:    cur_vec = vec_ff[1];
         default: cur_vec = vec_ff[2];
      endcase
   end

   assign cur_mag  = cur_vec[32] ? 32'(-cur_vec) : 32'(cur_vec);
   assign dv_numer = {1'b0, cur_mag, 14'b0} + 47'(len_ff >> 1);
   assign nrm_val  = (len_ff == '0) ? 16'sd0 :
                     (cur_vec[32] ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot}));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr_a[i] = (phase_ff == 2'd1) ? fr_ff[i] : rt_ff[i];
         cr_b[i] = (phase_ff == 2'd1) ? wu_ff[i] : fr_ff[i];
      end
      case (cnt_ff)
         3'd0:    begin term_a = cr_a[1]; term_b = cr_b[2]; end
         3'd1:    begin term_a = cr_a[2]; term_b = cr_b[1]; end
         3'd2:    begin term_a = cr_a[2]; term_b = cr_b[0]; end
         3'd3:    begin term_a = cr_a[0]; term_b = cr_b[2]; end
         3'd4:    begin term_a = cr_a[0]; term_b = cr_b[1]; end
         3'd5:    begin term_a = cr_a[1]; term_b = cr_b[0]; end
         default: begin term_a = '0;      term_b = '0;      end
      endcase
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_ANG_X: begin mul_a = 33'(dx_ff); mul_b = $signed({17'b0, gain_ff}); end
         ST_ANG_Y: begin mul_a = 33'(dy_ff); mul_b = $signed({17'b0, gain_ff}); end
         ST_FR0:   begin mul_a = cy_ff; mul_b = cp_ff; end
         ST_FR1:   begin mul_a = sy_ff; mul_b = cp_ff; end
         ST_NSQ:   begin mul_a = cur_vec; mul_b = cur_vec; end
         ST_CROSS: begin mul_a = 33'(term_a); mul_b = 33'(term_b); end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign load_yaw = (csr_wdata >= FULL_TURN) ? csr_wdata - FULL_TURN : csr_wdata;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      clamp_in     = clamp_ff;
      gain_in      = gain_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      red_in       = red_ff;
      preg_in      = preg_ff;
      cy_in        = cy_ff;
      sy_in        = sy_ff;
      cp_in        = cp_ff;
      sp_in        = sp_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      for (int i = 0; i < 3; i++) begin
         wu_in[i]  = wu_ff[i];
         vec_in[i] = vec_ff[i];
         fr_in[i]  = fr_ff[i];
         rt_in[i]  = rt_ff[i];
         up_in[i]  = up_ff[i];
      end
      req_tready = 1'b0;
      cor_start  = 1'b0;
      cor_angle  = $signed({1'b0, yaw_ff});
      sq_start   = 1'b0;
      dv_start   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dx_in    = $signed(req_tdata[15:0]);
               dy_in    = $signed(req_tdata[31:16]);
               clamp_in = req_tuser;
               state_in = ST_ANG_X;
            end
         end
         ST_ANG_X: state_in = ST_ANG_Y;
         ST_ANG_Y: begin
            red_in   = 34'(yaw_sum) + WRAP_BIAS;
            state_in = ST_PIT;
         end
         ST_PIT: begin
            preg_in = pit_sum;
            if (clamp_ff) begin
               if (pit_sum >= $signed(34'(PITCH_LIMIT))) begin
                  preg_in = $signed(34'(PITCH_LIMIT));
               end else if (pit_sum <= -$signed(34'(PITCH_LIMIT))) begin
                  preg_in = -$signed(34'(PITCH_LIMIT));
               end
            end
            cnt_in   = 3'd7;
            state_in = ST_RED_YAW;
         end
         ST_RED_YAW: begin
            red_in = red_next;
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               yaw_in   = red_next[24:0];
               red_in   = 34'(preg_ff) + 34'(HALF_TURN) + WRAP_BIAS;
               cnt_in   = 3'd7;
               state_in = ST_RED_PIT;
            end
         end
         ST_RED_PIT: begin
            red_in = red_next;
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               pitch_in = $signed(red_next[24:0] - HALF_TURN);
               state_in = ST_CY_GO;
            end
         end
         ST_CY_GO: begin
            cor_start = 1'b1;
            state_in  = ST_CY_WAIT;
         end
         ST_CY_WAIT: begin
            if (cor_done) begin
               cy_in    = cor_cos;
               sy_in    = cor_sin;
               state_in = ST_CP_GO;
            end
         end
         ST_CP_GO: begin
            cor_start = 1'b1;
            cor_angle = 26'(pitch_ff);
            state_in  = ST_CP_WAIT;
         end
         ST_CP_WAIT: begin
            if (cor_done) begin
               cp_in    = cor_cos;
               sp_in    = cor_sin;
               state_in = ST_FR0;
            end
         end
         ST_FR0: state_in = ST_FR1;
         ST_FR1: begin
            vec_in[0] = rnd_prod;
            state_in  = ST_FR2;
         end
         ST_FR2: begin
            vec_in[2] = rnd_prod;
            vec_in[1] = sp_ff;
            phase_in  = 2'd0;
            cnt_in    = '0;
            sum_in    = '0;
            state_in  = ST_NSQ;
         end
         ST_NSQ: begin
            // square issued at one count, summed at the next
            if (cnt_ff != 3'd0) begin
               sum_in = sum_ff + product_ff[63:0];
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            sq_start = 1'b1;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (sq_done) begin
               len_in   = sq_root;
               cnt_in   = '0;
               state_in = ST_DV_GO;
            end
         end
         ST_DV_GO: begin
            dv_start = 1'b1;
            state_in = ST_DV_WAIT;
         end
         ST_DV_WAIT: begin
            if (dv_done) begin
               case (phase_ff)
                  2'd0:    fr_in[cnt_ff[1:0]] = nrm_val;
                  2'd1:    rt_in[cnt_ff[1:0]] = nrm_val;
                  default: up_in[cnt_ff[1:0]] = nrm_val;
               endcase
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_DV_GO;
               if (cnt_ff == 3'd2) begin
                  cnt_in   = '0;
                  phase_in = phase_ff + 2'd1;
                  state_in = (phase_ff == 2'd2) ? ST_DONE : ST_CROSS;
               end
            end
         end
         ST_CROSS: begin
            // even terms open a component, odd terms are subtracted
            if (cnt_ff != 3'd0) begin
               case (cnt_ff)
                  3'd1:    vec_in[0] = product_ff[32:0];
                  3'd2:    vec_in[0] = vec_ff[0] - product_ff[32:0];
                  3'd3:    vec_in[1] = product_ff[32:0];
                  3'd4:    vec_in[1] = vec_ff[1] - product_ff[32:0];
                  3'd5:    vec_in[2] = product_ff[32:0];
                  default: vec_in[2] = vec_ff[2] - product_ff[32:0];
               endcase
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_NSQ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, pitch_ff, yaw_ff,
                               up_ff[2], up_ff[1], up_ff[0],
                               rt_ff[2], rt_ff[1], rt_ff[0],
                               fr_ff[2], fr_ff[1], fr_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_MOUSE_GAIN:  gain_in  = csr_wdata[15:0];
            CSR_WORLD_UP_X:  wu_in[0] = $signed(csr_wdata[15:0]);
            CSR_WORLD_UP_Y:  wu_in[1] = $signed(csr_wdata[15:0]);
            CSR_WORLD_UP_Z:  wu_in[2] = $signed(csr_wdata[15:0]);
            CSR_START_YAW:   yaw_in   = load_yaw;
            CSR_START_PITCH: pitch_in = 25'($signed(csr_wdata[23:0]));
            default:         gain_in  = gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= 16'd3277;
         wu_ff[0]     <= 16'sd0;
         wu_ff[1]     <= 16'sd16384;
         wu_ff[2]     <= 16'sd0;
         yaw_ff       <= 25'd17694720;
         pitch_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         wu_ff        <= wu_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      clamp_ff    <= clamp_in;
      red_ff      <= red_in;
      preg_ff     <= preg_in;
      cy_ff       <= cy_in;
      sy_ff       <= sy_in;
      cp_ff       <= cp_in;
      sp_ff       <= sp_in;
      vec_ff      <= vec_in;
      sum_ff      <= sum_in;
      len_ff      <= len_in;
      fr_ff       <= fr_in;
      rt_ff       <= rt_in;
      up_ff       <= up_in;
      product_ff  <= mul_a * mul_b;
      rsp_data_ff <= rsp_data_in;
   end

   ypcb_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_val (cor_cos),
      .sin_val (cor_sin)
   );

   ypcb_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   ypcb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .numer (dv_numer),
      .denom (len_ff),
      .done  (dv_done),
      .quot  (dv_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/ypcb_checker.sv =====
// port-level checks for the camera basis block, bound to the top level
module ypcb_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata
);

   // an accepted item keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on back-to-back cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_front_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[15:0]) <= 16'sd16384
                  && $signed(rsp_tdata[15:0]) >= -16'sd16384
                  && $signed(rsp_tdata[31:16]) <= 16'sd16384
                  && $signed(rsp_tdata[31:16]) >= -16'sd16384)
      else $error("front component beyond unit scale");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[199:194] == 6'b0 && rsp_tdata[168:144] < 25'd23592960)
      else $error("bad fill bits or yaw out of range");

endmodule

bind yaw_pitch_camera_basis_top ypcb_checker u_ypcb_checker (.*);
